// ===== design/bsp_pkg.sv =====
// Shared constants and types for the breadth-first shortest path block.
`default_nettype none
package bsp_pkg;
	localparam int NODES_DEF      = 32;
	localparam int MAX_DEGREE_DEF = 8;
	localparam int ID_W           = 5;

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_RUN      = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_ED_RDA   = 14'b00000000000010,
		S_ED_RDB   = 14'b00000000000100,
		S_ED_CHK   = 14'b00000000001000,
		S_ED_W2    = 14'b00000000010000,
		S_ED_OUT   = 14'b00000000100000,
		S_RUN_INIT = 14'b00000001000000,
		S_DEQ      = 14'b00000010000000,
		S_DQ_WAIT  = 14'b00000100000000,
		S_DQ_INFO  = 14'b00001000000000,
		S_NB_RD    = 14'b00010000000000,
		S_NB_CHK   = 14'b00100000000000,
		S_EM_RD    = 14'b01000000000000,
		S_EM_OUT   = 14'b10000000000000
	} state_t;
endpackage
`default_nettype wire

// ===== design/bfs_shortest_path_unweighted.sv =====
// Edge item: two degree reads, check, two table writes, result (rejected edges
// skip the writes). Run item: start, then per dequeued node a queue read, info
// and degree reads and a read and check per adjacency entry, then per result an
// info read and output load while the output is not stalled. The single-port
// adjacency, node-info and queue memories set the pace. Reset clears degree
// valid bits, visited marks and control state; memories need no clearing pass.
`default_nettype none
module bfs_shortest_path_unweighted import bsp_pkg::*; #(
	parameter int NODES      = NODES_DEF,
	parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic            command,
	input  wire logic [ID_W-1:0] first_node,
	input  wire logic [ID_W-1:0] second_node,
	input  wire logic [ID_W-1:0] source_node,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 status,
	output logic [ID_W-1:0]      node_index,
	output logic                 reached,
	output logic [ID_W-1:0]      hop_distance,
	output logic [ID_W-1:0]      predecessor,
	output logic                 has_predecessor,
	output logic                 last
);
	localparam int NW    = $clog2(NODES);
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int TW    = $clog2(NODES + 1);
	localparam int ADEP  = NODES * MAX_DEGREE;
	localparam int AAW   = $clog2(ADEP);
	localparam int EMIT  = (NODES < 32) ? NODES : 32;
	localparam int IW    = 1 + NW + ID_W;

	function automatic logic [AAW-1:0] adj_addr(input logic [NW-1:0] node,
			input logic [DW-1:0] slot);
		adj_addr = AAW'(node) * AAW'(MAX_DEGREE) + AAW'(slot);
	endfunction

	state_t state_q, state_d;

	logic            cmd_q;
	logic [ID_W-1:0] a_q, b_q, src_q;
	logic [DW-1:0]   da_q, db_q, deg_q, k_q;
	logic            rej_q;
	logic [TW-1:0]   head_q, tail_q;
	logic [NW-1:0]   u_q, n_q;
	logic [ID_W-1:0] du_q;
	logic [NODES-1:0] visited_q, deg_valid_q;

	logic            out_valid_q, status_q, reached_q, has_pred_q, last_q;
	logic [ID_W-1:0] node_index_q, hop_q, pred_q;

	// Memory control.
	logic            adj_we, adj_re, deg_we, deg_re, inf_we, inf_re, q_we, q_re;
	logic [AAW-1:0]  adj_addr_c;
	logic [ID_W-1:0] adj_wdata, adj_rdata;
	logic [NW-1:0]   deg_addr, inf_addr, q_addr;
	logic [DW-1:0]   deg_wdata, deg_rdata;
	logic [IW-1:0]   inf_wdata, inf_rdata;
	logic [NW-1:0]   q_wdata, q_rdata;

	logic            out_free, load_out, self_loop, reject_c, take_nb, src_ok;
	logic [DW-1:0]   db_c, deg_u_c;
	logic [NW-1:0]   x_c;

	assign out_free  = !out_valid_q || !out_stall;
	assign self_loop = (a_q == b_q);
	assign db_c      = deg_valid_q[NW'(b_q)] ? deg_rdata : '0;
	assign deg_u_c   = deg_valid_q[u_q] ? deg_rdata : '0;
	assign src_ok    = int'(src_q) < NODES;
	assign x_c       = NW'(adj_rdata);
	assign take_nb   = (int'(adj_rdata) < NODES) && !visited_q[x_c] && (int'(tail_q) < NODES);

	always_comb begin
		reject_c = 1'b0;
		if (int'(a_q) >= NODES || int'(b_q) >= NODES) begin
			reject_c = 1'b1;
		end else if (self_loop) begin
			reject_c = (int'(da_q) + 2) > MAX_DEGREE;
		end else begin
			reject_c = (int'(da_q) >= MAX_DEGREE) || (int'(db_c) >= MAX_DEGREE);
		end
	end

	always_comb begin
		state_d    = state_q;
		adj_we     = 1'b0;
		adj_re     = 1'b0;
		adj_addr_c = adj_addr(u_q, k_q);
		adj_wdata  = b_q;
		deg_we     = 1'b0;
		deg_re     = 1'b0;
		deg_addr   = NW'(a_q);
		deg_wdata  = '0;
		inf_we     = 1'b0;
		inf_re     = 1'b0;
		inf_addr   = n_q;
		inf_wdata  = {1'b1, u_q, ID_W'(du_q + 1'b1)};
		q_we       = 1'b0;
		q_re       = 1'b0;
		q_addr     = NW'(tail_q);
		q_wdata    = x_c;
		load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (command == CMD_RUN) ? S_RUN_INIT : S_ED_RDA;
				end
			end
			S_ED_RDA: begin
				deg_re  = 1'b1;
				state_d = S_ED_RDB;
			end
			S_ED_RDB: begin
				deg_re   = 1'b1;
				deg_addr = NW'(b_q);
				state_d  = S_ED_CHK;
			end
			S_ED_CHK: begin
				if (reject_c) begin
					state_d = S_ED_OUT;
				end else begin
					adj_we     = 1'b1;
					adj_addr_c = adj_addr(NW'(a_q), da_q);
					adj_wdata  = self_loop ? a_q : b_q;
					deg_we     = 1'b1;
					deg_wdata  = self_loop ? DW'(da_q + 2'd2) : DW'(da_q + 1'b1);
					state_d    = S_ED_W2;
				end
			end
			S_ED_W2: begin
				adj_we = 1'b1;
				adj_wdata = a_q;
				if (self_loop) begin
					adj_addr_c = adj_addr(NW'(a_q), DW'(da_q + 1'b1));
				end else begin
					adj_addr_c = adj_addr(NW'(b_q), db_q);
					deg_we     = 1'b1;
					deg_addr   = NW'(b_q);
					deg_wdata  = DW'(db_q + 1'b1);
				end
				state_d = S_ED_OUT;
			end
			S_ED_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_RUN_INIT: begin
				if (src_ok) begin
					inf_we    = 1'b1;
					inf_addr  = NW'(src_q);
					inf_wdata = '0;
					q_we      = 1'b1;
					q_addr    = '0;
					q_wdata   = NW'(src_q);
					state_d   = S_DEQ;
				end else begin
					state_d = S_EM_RD;
				end
			end
			S_DEQ: begin
				if (head_q < tail_q) begin
					q_re    = 1'b1;
					q_addr  = NW'(head_q);
					state_d = S_DQ_WAIT;
				end else begin
					state_d = S_EM_RD;
				end
			end
			S_DQ_WAIT: begin
				inf_re   = 1'b1;
				inf_addr = q_rdata;
				deg_re   = 1'b1;
				deg_addr = q_rdata;
				state_d  = S_DQ_INFO;
			end
			S_DQ_INFO: begin
				state_d = S_NB_RD;
			end
			S_NB_RD: begin
				if (k_q < deg_q) begin
					adj_re  = 1'b1;
					state_d = S_NB_CHK;
				end else begin
					state_d = S_DEQ;
				end
			end
			S_NB_CHK: begin
				if (take_nb) begin
					inf_we   = 1'b1;
					inf_addr = x_c;
					q_we     = 1'b1;
				end
				state_d = S_NB_RD;
			end
			S_EM_RD: begin
				inf_re  = 1'b1;
				state_d = S_EM_OUT;
			end
			S_EM_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = (int'(n_q) == EMIT - 1) ? S_IDLE : S_EM_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			visited_q   <= '0;
			deg_valid_q <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (deg_we) begin
				deg_valid_q[deg_addr] <= 1'b1;
			end
			if (state_q == S_RUN_INIT) begin
				visited_q <= src_ok ? (NODES'(1) << NW'(src_q)) : '0;
				head_q <= '0;
				tail_q <= src_ok ? TW'(1) : '0;
				n_q    <= '0;
			end
			if (q_re) begin
				head_q <= TW'(head_q + 1'b1);
			end
			if (state_q == S_DQ_INFO) begin
				k_q <= '0;
			end
			if (adj_re) begin
				k_q <= DW'(k_q + 1'b1);
			end
			if (state_q == S_NB_CHK && take_nb) begin
				visited_q[x_c] <= 1'b1;
				tail_q         <= TW'(tail_q + 1'b1);
			end
			if (state_q == S_EM_OUT && load_out) begin
				n_q <= NW'(n_q + 1'b1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= command;
			a_q   <= first_node;
			b_q   <= second_node;
			src_q <= source_node;
		end
		if (state_q == S_ED_RDB) begin
			da_q <= deg_valid_q[NW'(a_q)] ? deg_rdata : '0;
		end
		if (state_q == S_ED_CHK) begin
			db_q  <= db_c;
			rej_q <= reject_c;
		end
		if (state_q == S_DQ_WAIT) begin
			u_q <= q_rdata;
		end
		if (state_q == S_DQ_INFO) begin
			deg_q <= deg_u_c;
			du_q  <= inf_rdata[ID_W-1:0];
		end
		if (load_out) begin
			if (state_q == S_ED_OUT) begin
				status_q     <= rej_q ? STATUS_FULL : STATUS_OK;
				node_index_q <= '0;
				reached_q    <= 1'b0;
				hop_q        <= '0;
				pred_q       <= '0;
				has_pred_q   <= 1'b0;
				last_q       <= 1'b1;
			end else begin
				status_q     <= STATUS_OK;
				node_index_q <= ID_W'(n_q);
				reached_q    <= visited_q[n_q];
				hop_q        <= visited_q[n_q] ? inf_rdata[ID_W-1:0] : '0;
				pred_q       <= (visited_q[n_q] && inf_rdata[IW-1]) ?
						ID_W'(inf_rdata[IW-2:ID_W]) : '0;
				has_pred_q   <= visited_q[n_q] && inf_rdata[IW-1];
				last_q       <= (int'(n_q) == EMIT - 1);
			end
		end
	end

	bsp_ram #(.WIDTH(ID_W), .DEPTH(ADEP)) u_adj (
		.clk(clk), .we(adj_we), .re(adj_re), .addr(adj_addr_c),
		.wdata(adj_wdata), .rdata(adj_rdata)
	);
	bsp_ram #(.WIDTH(DW), .DEPTH(NODES)) u_deg (
		.clk(clk), .we(deg_we), .re(deg_re), .addr(deg_addr),
		.wdata(deg_wdata), .rdata(deg_rdata)
	);
	// Node info: predecessor valid, predecessor, hop distance.
	bsp_ram #(.WIDTH(IW), .DEPTH(NODES)) u_info (
		.clk(clk), .we(inf_we), .re(inf_re), .addr(inf_addr),
		.wdata(inf_wdata), .rdata(inf_rdata)
	);
	bsp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
		.clk(clk), .we(q_we), .re(q_re), .addr(q_addr),
		.wdata(q_wdata), .rdata(q_rdata)
	);

	assign in_stall        = (state_q != S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign node_index      = node_index_q;
	assign reached         = reached_q;
	assign hop_distance    = hop_q;
	assign predecessor     = pred_q;
	assign has_predecessor = has_pred_q;
	assign last            = last_q;

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_q) <= NODES)
		else $error("queue tail beyond node count");
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");
	a_unreached: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !reached) |-> (hop_distance == '0 && !has_predecessor))
		else $error("unreached node carries path data");
	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (last && !reached))
		else $error("rejected edge result malformed");
	a_cmd_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN_INIT) |-> (cmd_q == CMD_RUN))
		else $error("run sequence entered for edge item");
endmodule
`default_nettype wire

// ===== design/bsp_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module bsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

// ===== tb/bfs_shortest_path_unweighted_tb.sv =====
// Self-checking testbench for the breadth-first shortest path block.
`default_nettype none
module bfs_shortest_path_unweighted_tb;
	import bsp_pkg::*;

	localparam int N   = NODES_DEF;
	localparam int DEG = MAX_DEGREE_DEF;

	typedef struct packed {
		logic            command;
		logic [ID_W-1:0] first_node;
		logic [ID_W-1:0] second_node;
		logic [ID_W-1:0] source_node;
	} graph_cmd_t;

	typedef struct packed {
		logic            status;
		logic [ID_W-1:0] node_index;
		logic            reached;
		logic [ID_W-1:0] hop_distance;
		logic [ID_W-1:0] predecessor;
		logic            has_predecessor;
		logic            last;
	} node_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [ID_W-1:0] first_node = '0;
	logic [ID_W-1:0] second_node = '0;
	logic [ID_W-1:0] source_node = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [ID_W-1:0] node_index;
	logic reached;
	logic [ID_W-1:0] hop_distance;
	logic [ID_W-1:0] predecessor;
	logic has_predecessor;
	logic last;

	graph_cmd_t   pending_cmds[$];
	node_report_t expected_reports[$];
	int  errors = 0;
	bit  quiet_tail = 1'b0;
	int  in_idle = 0;
	int  out_idle = 0;

	// Predictor state: adjacency lists and degrees.
	logic [ID_W-1:0] adj_list[N][DEG];
	int              degree[N];

	always #4 clk = ~clk;

	bfs_shortest_path_unweighted dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .first_node(first_node), .second_node(second_node),
		.source_node(source_node), .out_valid(out_valid), .out_stall(out_stall),
		.status(status), .node_index(node_index), .reached(reached),
		.hop_distance(hop_distance), .predecessor(predecessor),
		.has_predecessor(has_predecessor), .last(last)
	);

	function automatic logic try_add_edge(int a, int b);
		if (a == b) begin
			if (degree[a] + 2 > DEG) return STATUS_FULL;
			adj_list[a][degree[a]++] = a[ID_W-1:0];
			adj_list[a][degree[a]++] = a[ID_W-1:0];
			return STATUS_OK;
		end
		if (degree[a] >= DEG || degree[b] >= DEG) return STATUS_FULL;
		adj_list[a][degree[a]++] = b[ID_W-1:0];
		adj_list[b][degree[b]++] = a[ID_W-1:0];
		return STATUS_OK;
	endfunction

	task automatic predict_reports(graph_cmd_t c);
		node_report_t r;
		bit seen[N];
		int hops[N];
		int pred[N];
		bit has_pred[N];
		int fifo[$];
		int u;
		int x;
		if (c.command == CMD_ADD_EDGE) begin
			r = '0;
			r.status = try_add_edge(c.first_node, c.second_node);
			r.last = 1'b1;
			expected_reports = {expected_reports, r};
			return;
		end
		for (int i = 0; i < N; i++) begin
			seen[i] = 0; hops[i] = 0; pred[i] = 0; has_pred[i] = 0;
		end
		seen[c.source_node] = 1;
		fifo = {fifo, int'(c.source_node)};
		while (fifo.size() > 0) begin
			u = fifo.pop_front();
			for (int k = 0; k < degree[u]; k++) begin
				x = adj_list[u][k];
				if (!seen[x]) begin
					seen[x] = 1; hops[x] = hops[u] + 1; pred[x] = u; has_pred[x] = 1;
					fifo = {fifo, x};
				end
			end
		end
		for (int i = 0; i < N; i++) begin
			r = '0;
			r.node_index = i[ID_W-1:0];
			r.reached = seen[i];
			r.hop_distance = seen[i] ? hops[i][ID_W-1:0] : '0;
			r.predecessor = has_pred[i] ? pred[i][ID_W-1:0] : '0;
			r.has_predecessor = has_pred[i];
			r.last = (i == N - 1);
			expected_reports = {expected_reports, r};
		end
	endtask

	function automatic graph_cmd_t make_edge(int a, int b);
		graph_cmd_t c;
		c = '0;
		c.command = CMD_ADD_EDGE;
		c.first_node = a[ID_W-1:0];
		c.second_node = b[ID_W-1:0];
		c.source_node = ID_W'($urandom);
		return c;
	endfunction

	function automatic graph_cmd_t make_run(int s);
		graph_cmd_t c;
		c = '0;
		c.command = CMD_RUN;
		c.first_node = ID_W'($urandom);
		c.second_node = ID_W'($urandom);
		c.source_node = s[ID_W-1:0];
		return c;
	endfunction

	// Driver: the payload holds while stalled; the next item may follow at once or after a random idle gap.
	always @(posedge clk) begin
		graph_cmd_t c;
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_idle > 0) begin
					in_idle <= in_idle - 1;
					in_valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
					in_idle <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					c = pending_cmds.pop_front();
					predict_reports(c);
					in_valid <= 1'b1;
					command <= c.command;
					first_node <= c.first_node;
					second_node <= c.second_node;
					source_node <= c.source_node;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and receiver stall pattern.
	always @(posedge clk) begin
		node_report_t exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected result node_index=%0d", node_index);
					errors++;
				end else begin
					exp_r = expected_reports.pop_front();
					if (status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, status); errors++;
					end
					if (node_index !== exp_r.node_index) begin
						$error("node_index exp %0d got %0d", exp_r.node_index, node_index);
						errors++;
					end
					if (reached !== exp_r.reached) begin
						$error("reached exp %0d got %0d", exp_r.reached, reached); errors++;
					end
					if (hop_distance !== exp_r.hop_distance) begin
						$error("hop_distance exp %0d got %0d", exp_r.hop_distance,
							hop_distance);
						errors++;
					end
					if (predecessor !== exp_r.predecessor) begin
						$error("predecessor exp %0d got %0d", exp_r.predecessor, predecessor);
						errors++;
					end
					if (has_predecessor !== exp_r.has_predecessor) begin
						$error("has_predecessor exp %0d got %0d", exp_r.has_predecessor,
							has_predecessor);
						errors++;
					end
					if (last !== exp_r.last) begin
						$error("last exp %0d got %0d", exp_r.last, last); errors++;
					end
				end
			end
			if (out_idle > 0) begin
				out_idle <= out_idle - 1;
				out_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_idle <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int total;
		int a;
		int b;
		for (int i = 0; i < N; i++) degree[i] = 0;
		// Directed part: run on empty graph, extremes, self-loops, full lists.
		pending_cmds = {pending_cmds, make_run(0)};
		pending_cmds = {pending_cmds, make_edge(0, 31)};
		pending_cmds = {pending_cmds, make_edge(31, 31)};
		pending_cmds = {pending_cmds, make_edge(5, 5)};
		for (int i = 1; i <= 8; i++) pending_cmds = {pending_cmds, make_edge(0, i)};
		pending_cmds = {pending_cmds, make_edge(0, 9)};
		pending_cmds = {pending_cmds, make_edge(9, 0)};
		pending_cmds = {pending_cmds, make_edge(1, 10)};
		pending_cmds = {pending_cmds, make_edge(10, 20)};
		pending_cmds = {pending_cmds, make_run(0)};
		pending_cmds = {pending_cmds, make_run(31)};
		pending_cmds = {pending_cmds, make_run(20)};
		pending_cmds = {pending_cmds, make_run(5)};
		pending_cmds = {pending_cmds, make_run(30)};
		total = pending_cmds.size();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// Random graphs: mostly edges among a small cluster, with searches between.
		while (total < 470) begin
			if ($urandom_range(0, 7) == 0) begin
				pending_cmds = {pending_cmds, make_run($urandom_range(0, 31))};
			end else begin
				a = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 11);
				b = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 11);
				pending_cmds = {pending_cmds, make_edge(a, b)};
			end
			total++;
			if (total == 400) quiet_tail = 1'b1;
			while (pending_cmds.size() > 4) @(posedge clk);
		end
		while (pending_cmds.size() > 0 || in_valid) @(posedge clk);
		while (expected_reports.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_reports.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
